/* rtl/core/rc5_edge_timing_decoder_assert.svh */
// assertion macros for the rc5 edge timing decoder
// no dependencies; included by the top level only
`ifndef RC5_EDGE_TIMING_DECODER_ASSERT_SVH
`define RC5_EDGE_TIMING_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RC5_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define RC5_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

/* rtl/core/rc5_pkg.sv */
// types and constants shared by the rc5 edge timing decoder
// no dependencies
package rc5_pkg;

	localparam int TICK_W     = 16;
	localparam int COUNT_W    = 4;
	localparam int SHIFT_W    = 13;
	localparam int ADDR_W     = 5;
	localparam int CMD_W      = 6;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [COUNT_W-1:0] LAST_BIT_BEFORE = 4'd13;

	localparam logic [TICK_W-1:0] SHORT_MIN_RST = 16'd16020;
	localparam logic [TICK_W-1:0] SHORT_MAX_RST = 16'd21263;
	localparam logic [TICK_W-1:0] LONG_MIN_RST  = 16'd32041;
	localparam logic [TICK_W-1:0] LONG_MAX_RST  = 16'd42526;

	typedef enum logic [1:0] {
		REG_SHORT_MIN = 2'd0,
		REG_SHORT_MAX = 2'd1,
		REG_LONG_MIN  = 2'd2,
		REG_LONG_MAX  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0] interval_ticks;
		logic              edge_rising;
	} edge_item_t;

	typedef struct packed {
		logic              toggle_bit;
		logic [ADDR_W-1:0] device_address;
		logic [CMD_W-1:0]  command_code;
	} frame_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] short_min_ticks;
		logic [TICK_W-1:0] short_max_ticks;
		logic [TICK_W-1:0] long_min_ticks;
		logic [TICK_W-1:0] long_max_ticks;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bits_taken;
		logic [SHIFT_W-1:0] frame_shift;
		logic               at_boundary;
	} frame_state_t;

endpackage

/* rtl/core/rc5_edge_timing_decoder.sv */
// top level of the rc5 edge timing decoder: edge register, frame tracker, result register
// depends on rc5_pkg, rc5_cfg_regs, rc5_frame and rc5_edge_timing_decoder_assert.svh
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  edge     | in        | edge_valid / edge_stall  | edge_data (interval, polarity)
//  frame    | out       | frame_valid / frame_stall| frame_data (toggle, address, command)
//  config   | in        | psel / penable / pready  | paddr, pwdata, prdata
//
// one edge transaction per cycle while edge_stall is low; an edge is registered in the edge
// register, then goes through a single pass of window compares and a 13-bit shift
// into the result register
// reset clears the tracker to idle and loads the default timing windows
// edge_stall rises only when a finished frame sits stalled in the result register
// and the edge held in the edge register would produce another frame
module rc5_edge_timing_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          edge_valid,
	output logic                          edge_stall,
	input  rc5_pkg::edge_item_t           edge_data,
	output logic                          frame_valid,
	input  logic                          frame_stall,
	output rc5_pkg::frame_item_t          frame_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rc5_pkg::PADDR_W-1:0]   paddr,
	input  logic [rc5_pkg::PDATA_W-1:0]   pwdata,
	output logic [rc5_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

`include "rc5_edge_timing_decoder_assert.svh"

	rc5_pkg::cfg_t         cfg;
	rc5_pkg::edge_item_t   edge_s1;
	logic                  edge_valid_s1;
	logic                  res_valid;
	rc5_pkg::frame_item_t  res_item;
	rc5_pkg::frame_state_t trk_state;
	rc5_pkg::frame_item_t  frame_q;
	logic                  frame_valid_q;
	logic                  advance;
	logic                  edge_acc;
	logic                  frame_acc;

	// timing window registers
	rc5_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held edge moves on unless it makes a frame and the result slot is blocked
	assign advance    = edge_valid_s1 && (!res_valid || !frame_valid_q || !frame_stall);
	assign edge_stall = edge_valid_s1 && !advance;
	assign edge_acc   = edge_valid && !edge_stall;
	assign frame_acc  = frame_valid_q && !frame_stall;

	// edge register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid_s1 <= 1'b0;
		end else if (edge_acc) begin
			edge_valid_s1 <= 1'b1;
		end else if (advance) begin
			edge_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_acc) begin
			edge_s1 <= edge_data;
		end
	end

	// bit tracking and field extraction in one pass
	rc5_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.item      (edge_s1),
		.res_valid (res_valid),
		.res_item  (res_item),
		.state     (trk_state)
	);

	// result register, refilled in the same cycle its frame is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			frame_valid_q <= 1'b1;
		end else if (frame_acc) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			frame_q <= res_item;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_data  = frame_q;

	// checks on the tracker and the result slot
	`RC5_ASSERT_IMPLY(a_bits_bounded, clk, arst_n, 1'b1, trk_state.bits_taken <= rc5_pkg::LAST_BIT_BEFORE)
	`RC5_ASSERT_IMPLY(a_idle_clean, clk, arst_n, trk_state.bits_taken == '0, (trk_state.frame_shift == '0) && !trk_state.at_boundary)
	`RC5_ASSERT_NEXT(a_frame_loaded, clk, arst_n, advance && res_valid, frame_valid && (frame_data == $past(res_item)))

endmodule

/* rtl/core/rc5_cfg_regs.sv */
// apb-style register file holding the four timing windows
// depends on rc5_pkg
module rc5_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rc5_pkg::PADDR_W-1:0]   paddr,
	input  logic [rc5_pkg::PDATA_W-1:0]   pwdata,
	output logic [rc5_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output rc5_pkg::cfg_t                 cfg
);

	rc5_pkg::cfg_t     cfg_q;
	rc5_pkg::reg_idx_t idx;
	logic              wr_en;
	logic [rc5_pkg::TICK_W-1:0] rd_val;

	assign idx    = rc5_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min_ticks <= rc5_pkg::SHORT_MIN_RST;
			cfg_q.short_max_ticks <= rc5_pkg::SHORT_MAX_RST;
			cfg_q.long_min_ticks  <= rc5_pkg::LONG_MIN_RST;
			cfg_q.long_max_ticks  <= rc5_pkg::LONG_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				rc5_pkg::REG_SHORT_MIN: cfg_q.short_min_ticks <= pwdata[15:0];
				rc5_pkg::REG_SHORT_MAX: cfg_q.short_max_ticks <= pwdata[15:0];
				rc5_pkg::REG_LONG_MIN:  cfg_q.long_min_ticks  <= pwdata[15:0];
				rc5_pkg::REG_LONG_MAX:  cfg_q.long_max_ticks  <= pwdata[15:0];
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rc5_pkg::REG_SHORT_MIN: rd_val = cfg_q.short_min_ticks;
			rc5_pkg::REG_SHORT_MAX: rd_val = cfg_q.short_max_ticks;
			rc5_pkg::REG_LONG_MIN:  rd_val = cfg_q.long_min_ticks;
			rc5_pkg::REG_LONG_MAX:  rd_val = cfg_q.long_max_ticks;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = {{(rc5_pkg::PDATA_W - rc5_pkg::TICK_W){1'b0}}, rd_val};

endmodule

/* rtl/core/rc5_frame.sv */
// frame tracker: window compares, bit taking and frame field extraction
// depends on rc5_pkg
module rc5_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rc5_pkg::cfg_t         cfg,
	input  logic                  step,
	input  rc5_pkg::edge_item_t   item,
	output logic                  res_valid,
	output rc5_pkg::frame_item_t  res_item,
	output rc5_pkg::frame_state_t state
);

	logic [rc5_pkg::COUNT_W-1:0] bits_q, bits_n;
	logic [rc5_pkg::SHIFT_W-1:0] shift_q, shift_n, shift_take;
	logic                        bound_q, bound_n;
	logic                        falling, is_short, is_long, take;
	logic [rc5_pkg::TICK_W-1:0]  t;

	assign t       = item.interval_ticks;
	assign falling = !item.edge_rising;

	// short wins where the windows overlap
	assign is_short = (t >= cfg.short_min_ticks) && (t <= cfg.short_max_ticks);
	assign is_long  = !is_short && (t >= cfg.long_min_ticks) && (t <= cfg.long_max_ticks);

	assign shift_take = {shift_q[rc5_pkg::SHIFT_W-2:0], falling};

	always_comb begin
		bits_n    = bits_q;
		shift_n   = shift_q;
		bound_n   = bound_q;
		take      = 1'b0;
		res_valid = 1'b0;
		if (bits_q == '0) begin
			// idle: a falling edge is start bit 1
			if (falling) begin
				bits_n  = 4'd1;
				shift_n = {{(rc5_pkg::SHIFT_W-1){1'b0}}, 1'b1};
				bound_n = 1'b0;
			end
		end else if ((!is_short && !is_long) || (is_long && bound_q)) begin
			bits_n  = '0;
			shift_n = '0;
			bound_n = 1'b0;
		end else begin
			if (is_short) begin
				take    = bound_q;
				bound_n = !bound_q;
			end else begin
				take = 1'b1;
			end
			if (take) begin
				if (bits_q == rc5_pkg::LAST_BIT_BEFORE) begin
					// fourteenth bit: emit when start bit 2 is set
					res_valid = shift_take[12];
					bits_n    = '0;
					shift_n   = '0;
					bound_n   = 1'b0;
				end else begin
					bits_n  = bits_q + 4'd1;
					shift_n = shift_take;
				end
			end
		end
	end

	assign res_item.toggle_bit     = shift_take[11];
	assign res_item.device_address = shift_take[10:6];
	assign res_item.command_code   = shift_take[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			shift_q <= '0;
			bound_q <= 1'b0;
		end else if (step) begin
			bits_q  <= bits_n;
			shift_q <= shift_n;
			bound_q <= bound_n;
		end
	end

	assign state.bits_taken  = bits_q;
	assign state.frame_shift = shift_q;
	assign state.at_boundary = bound_q;

endmodule

/* tb/sv/tb_rc5_edge_timing_decoder.sv */
`timescale 1ns / 1ps
// self-checking bench for the rc5 edge timing decoder: edge stimulus, frame checks, window setup
// depends on rc5_pkg and the rc5_edge_timing_decoder rtl
module tb_rc5_edge_timing_decoder;

	localparam int TICK_W      = rc5_pkg::TICK_W;
	localparam int FRAME_BITS  = 14;
	localparam int PHASE_EDGES = 120;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           edge_valid = 1'b0;
	logic                           edge_stall;
	rc5_pkg::edge_item_t            edge_data = '0;
	logic                           frame_valid;
	logic                           frame_stall = 1'b0;
	rc5_pkg::frame_item_t           frame_data;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [rc5_pkg::PADDR_W-1:0]    paddr = '0;
	logic [rc5_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [rc5_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	rc5_edge_timing_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_valid  (edge_valid),
		.edge_stall  (edge_stall),
		.edge_data   (edge_data),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_data  (frame_data),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs or drops a frame
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// shadow of the decoder: timing windows and frame tracking state
	// ------------------------------------------------------------------
	rc5_pkg::cfg_t     windows = '{rc5_pkg::SHORT_MIN_RST, rc5_pkg::SHORT_MAX_RST,
		rc5_pkg::LONG_MIN_RST, rc5_pkg::LONG_MAX_RST};
	logic [rc5_pkg::COUNT_W-1:0] track_bits = '0;
	logic [rc5_pkg::SHIFT_W-1:0] track_shift = '0;
	logic              track_boundary = 1'b0;

	rc5_pkg::edge_item_t  edges_pending[$];
	rc5_pkg::frame_item_t frames_due[$];
	int          mismatch_count = 0;
	int          phase_edges = 0;

	function automatic logic in_short(input logic [TICK_W-1:0] t);
		return t >= windows.short_min_ticks && t <= windows.short_max_ticks;
	endfunction

	// advances the shadow tracker by one edge; returns 1 when a frame comes out
	function automatic logic decode_edge(input rc5_pkg::edge_item_t e,
		output rc5_pkg::frame_item_t f);
		logic               is_short;
		logic               is_long;
		logic               take;
		logic [rc5_pkg::SHIFT_W-1:0] s;
		f = '0;
		// idle: only a falling edge opens a frame, as the first start bit
		if (track_bits == 0) begin
			if (!e.edge_rising) begin
				track_bits = 1;
				track_shift = 1;
				track_boundary = 1'b0;
			end
			return 1'b0;
		end
		// short wins where the two windows overlap
		is_short = in_short(e.interval_ticks);
		is_long = !is_short && e.interval_ticks >= windows.long_min_ticks
			&& e.interval_ticks <= windows.long_max_ticks;
		// off-window interval, or a full bit from a boundary, drops the frame
		if ((!is_short && !is_long) || (is_long && track_boundary)) begin
			{track_bits, track_shift, track_boundary} = '0;
			return 1'b0;
		end
		// half bit toggles mid-bit and boundary; a bit is taken on reaching mid-bit
		take = 1'b1;
		if (is_short) begin
			take = track_boundary;
			track_boundary = !track_boundary;
		end
		if (!take)
			return 1'b0;
		track_shift = {track_shift[rc5_pkg::SHIFT_W-2:0], !e.edge_rising};
		track_bits = track_bits + 1'b1;
		if (track_bits < FRAME_BITS)
			return 1'b0;
		s = track_shift;
		{track_bits, track_shift, track_boundary} = '0;
		// second start bit low: frame thrown away
		if (!s[rc5_pkg::SHIFT_W-1])
			return 1'b0;
		f.toggle_bit = s[11];
		f.device_address = s[10:6];
		f.command_code = s[5:0];
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_edge(input logic [TICK_W-1:0] t, input logic rising);
		rc5_pkg::edge_item_t e;
		e.interval_ticks = t;
		e.edge_rising = rising;
		edges_pending.push_back(e);
		phase_edges++;
	endtask

	function automatic logic [TICK_W-1:0] pick_short();
		if (windows.short_min_ticks > windows.short_max_ticks)
			return TICK_W'($urandom);
		return TICK_W'($urandom_range(windows.short_min_ticks, windows.short_max_ticks));
	endfunction

	// a full-bit interval that the short window does not swallow, where one exists
	function automatic logic [TICK_W-1:0] pick_long();
		logic [TICK_W-1:0] v;
		v = TICK_W'($urandom);
		if (windows.long_min_ticks <= windows.long_max_ticks) begin
			for (int i = 0; i < 8; i++) begin
				v = TICK_W'($urandom_range(windows.long_min_ticks, windows.long_max_ticks));
				if (!in_short(v))
					break;
			end
		end
		return v;
	endfunction

	// word[13] is the first start bit; sends bits 0..cut-1, with bit bad_k garbled if nonzero
	task automatic send_frame(input logic [13:0] word, input int cut, input int bad_k);
		logic bk;
		logic prev;
		// saturated rising edge: ignored when idle, flushes a half-received frame where no window covers it
		push_edge('1, 1'b1);
		push_edge(TICK_W'($urandom), 1'b0);
		for (int k = 1; k < cut; k++) begin
			bk = word[13-k];
			prev = word[14-k];
			if (k == bad_k) begin
				push_edge(TICK_W'($urandom), 1'($urandom));
			end else if (bk == prev) begin
				// repeated bit: boundary edge then mid-bit edge, half a bit apart
				push_edge(pick_short(), bk);
				push_edge(pick_short(), !bk);
			end else begin
				push_edge(pick_long(), !bk);
			end
		end
	endtask

	// mostly clean frames, some cut short or garbled, the rest loose edges
	task automatic random_phase();
		int          sel;
		logic [13:0] word;
		logic [TICK_W-1:0] bound;
		phase_edges = 0;
		while (phase_edges < PHASE_EDGES) begin
			sel = $urandom_range(0, 99);
			word = {1'b1, 1'($urandom_range(0, 9) != 0), 12'($urandom)};
			if (sel < 70) begin
				send_frame(word, FRAME_BITS, 0);
			end else if (sel < 85) begin
				send_frame(word, $urandom_range(2, FRAME_BITS), $urandom_range(0, 13));
			end else if (sel < 92) begin
				// just on or just off a window limit
				case ($urandom_range(0, 3))
					0: bound = windows.short_min_ticks;
					1: bound = windows.short_max_ticks;
					2: bound = windows.long_min_ticks;
					default: bound = windows.long_max_ticks;
				endcase
				push_edge(bound + TICK_W'($urandom_range(0, 2)) - 1'b1, 1'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					push_edge(TICK_W'($urandom), 1'($urandom));
			end
		end
	endtask

	// every transaction sent and every frame back, then room for an edge still in the pipe
	task automatic wait_drained();
		while (edges_pending.size() != 0 || edge_valid || frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup then access phase, pready is tied high; junk in the upper half
	task automatic write_window(input rc5_pkg::reg_idx_t idx, input logic [TICK_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rc5_pkg::REG_SHORT_MIN: windows.short_min_ticks = value;
			rc5_pkg::REG_SHORT_MAX: windows.short_max_ticks = value;
			rc5_pkg::REG_LONG_MIN:  windows.long_min_ticks = value;
			default:                windows.long_max_ticks = value;
		endcase
	endtask

	// ------------------------------------------------------------------
	// edge driver: bursts of transactions separated by random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid <= 1'b0;
			edge_data <= '0;
		end else if (!(edge_valid && edge_stall)) begin
			// payload is held while stalled, otherwise the next one goes out
			if (gap_left != 0) begin
				gap_left--;
				edge_valid <= 1'b0;
			end else if (edges_pending.size() != 0) begin
				edge_data <= edges_pending.pop_front();
				edge_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 9))
						0, 1, 2: gap_left = 0;
						3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
						default: gap_left = $urandom_range(5, 30);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				edge_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// frame receiver: stall pattern in spells, plus long hold-offs to back the block up
	// ------------------------------------------------------------------
	int stall_pct = 0;
	int spell_left = 0;
	int hold_left = 0;
	int holds_done = 0;
	int frames_taken = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_stall <= 1'b0;
		end else begin
			if (frame_valid && !frame_stall)
				frames_taken++;
			if (hold_left != 0) begin
				hold_left--;
				frame_stall <= 1'b1;
			end else if ((holds_done == 0 && frames_taken >= 3)
				|| (holds_done == 1 && frames_taken >= 40)) begin
				// edges keep coming meanwhile, so the result register fills and edge_stall rises
				hold_left = HOLD_CYCLES;
				holds_done++;
				frame_stall <= 1'b1;
			end else begin
				if (spell_left == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
					spell_left = $urandom_range(20, 120);
				end
				spell_left--;
				frame_stall <= $urandom_range(0, 99) < stall_pct;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on each accepted edge, check each accepted frame
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rc5_pkg::frame_item_t predicted;
		rc5_pkg::frame_item_t want;
		if (arst_n) begin
			if (edge_valid && !edge_stall) begin
				if (decode_edge(edge_data, predicted))
					frames_due.push_back(predicted);
			end
			if (frame_valid && !frame_stall) begin
				if (frames_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected frame transaction %p", frame_data));
				end else begin
					want = frames_due.pop_front();
					if (frame_data.toggle_bit !== want.toggle_bit)
						flag_mismatch($sformatf("toggle_bit got %b want %b",
							frame_data.toggle_bit, want.toggle_bit));
					if (frame_data.device_address !== want.device_address)
						flag_mismatch($sformatf("device_address got %0d want %0d",
							frame_data.device_address, want.device_address));
					if (frame_data.command_code !== want.command_code)
						flag_mismatch($sformatf("command_code got %0d want %0d",
							frame_data.command_code, want.command_code));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: reset, directed edges, then one random phase per window setting
	// ------------------------------------------------------------------
	logic [TICK_W-1:0] window_sets [0:7][0:3] = '{
		'{16'd0,     16'd0,     16'd1,     16'd1},      // tightest possible windows
		'{16'd500,   16'd900,   16'd700,   16'd1500},   // overlapping, short wins
		'{16'd3000,  16'd2000,  16'd5000,  16'd9000},   // short window empty
		'{16'd100,   16'd200,   16'd65535, 16'd0},      // long window empty
		'{16'd0,     16'd65535, 16'd0,     16'd65535},  // everything reads as short
		'{16'd65534, 16'd65535, 16'd65533, 16'd65535},  // top of the range
		'{16'd0,     16'd0,     16'd0,     16'd0},      // random, filled in below
		'{rc5_pkg::SHORT_MIN_RST, rc5_pkg::SHORT_MAX_RST,
			rc5_pkg::LONG_MIN_RST, rc5_pkg::LONG_MAX_RST}
	};

	initial begin
		logic bk;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed edges against the reset windows
		push_edge(16'h0000, 1'b1);                    // rising while idle, ignored
		push_edge(16'hFFFF, 1'b0);                    // frame start
		push_edge(16'h0000, 1'b1);                    // off both windows, back to idle
		push_edge(16'h0000, 1'b0);                    // start again, interval irrelevant
		push_edge(windows.short_min_ticks, 1'b0);     // to boundary
		push_edge(windows.long_max_ticks, 1'b1);      // full bit from boundary, dropped
		push_edge(16'hAAAA, 1'b0);                    // start
		push_edge(windows.short_max_ticks, 1'b1);     // to boundary
		push_edge(windows.short_min_ticks, 1'b0);     // mid-bit, takes a 1
		push_edge(windows.long_min_ticks, 1'b1);      // full bit, takes a 0
		push_edge(16'hFFFF, 1'b1);                    // saturated, back to idle
		// alternating bits with the second start bit low: decoded then discarded
		push_edge(16'h5555, 1'b0);
		for (int k = 1; k < FRAME_BITS; k++) begin
			bk = (k % 2) == 0;
			push_edge(pick_long(), !bk);
		end
		random_phase();
		wait_drained();

		window_sets[6][0] = $urandom_range(1, 20000);
		window_sets[6][1] = window_sets[6][0] + $urandom_range(0, 5000);
		window_sets[6][2] = window_sets[6][1] + $urandom_range(1, 10000);
		window_sets[6][3] = window_sets[6][2] + $urandom_range(0, 15000);

		for (int s = 0; s < 8; s++) begin
			write_window(rc5_pkg::REG_SHORT_MIN, window_sets[s][0]);
			write_window(rc5_pkg::REG_SHORT_MAX, window_sets[s][1]);
			write_window(rc5_pkg::REG_LONG_MIN, window_sets[s][2]);
			write_window(rc5_pkg::REG_LONG_MAX, window_sets[s][3]);
			random_phase();
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
